// ----- sv/ahdi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdi_pkg
// Shared types, constants and arithmetic helpers for the acceleration
// high-pass and double integration block.
// ----------------------------------------------------------------------------
`default_nettype none

package ahdi_pkg;

    localparam int AXES_MAX  = 3;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 240;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] REG_VEL_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP   = 2'd2;

    localparam logic [31:0] VEL_STEP_RST = 32'd419430;
    localparam logic [31:0] POS_STEP_RST = 32'd419430;
    localparam logic [7:0]  WARMUP_RST   = 8'd40;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE = 4'd0,
        OP_LOAD = 4'd1,
        OP_MUL  = 4'd2,
        OP_ACC  = 4'd3,
        OP_RND  = 4'd4,
        OP_FILT = 4'd5,
        OP_VMUL = 4'd6,
        OP_VADD = 4'd7,
        OP_PMUL = 4'd8,
        OP_PADD = 4'd9,
        OP_OUT  = 4'd10
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
        logic [1:0] stage;
        logic [2:0] term;
    } t_dp_cmd;

    // biquad coefficients, Q2.30, terms: b0 b1 b2 a1 a2
    function automatic logic signed [31:0] coef(input logic [1:0] stage,
                                                input logic [2:0] term);
        logic signed [31:0] c;
        c = 32'sd0;
        case ({stage, term})
            5'b00_000: c = 32'sd1039054389;
            5'b00_001: c = -32'sd2078108778;
            5'b00_010: c = 32'sd1039054389;
            5'b00_011: c = 32'sd2098093630;
            5'b00_100: c = -32'sd1025014616;
            5'b01_000: c = 32'sd1073741824;
            5'b01_001: c = 32'sh8000_0000;
            5'b01_010: c = 32'sd1073741824;
            5'b01_011: c = 32'sd2126356553;
            5'b01_100: c = -32'sd1053286467;
            5'b10_000: c = 32'sd1073741824;
            5'b11_000: c = 32'sd1073741824;
            default:   c = 32'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ahdi_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdi_ctrl
// Sequencer: warm-up counting, per axis and stage term loop, integration
// steps and the output register handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module ahdi_ctrl #(
    parameter int NUM_STAGES = 2,
    parameter int NUM_AXES   = 3
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    input  wire  [7:0]         i_warmup_items,
    output ahdi_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MUL  = 10'b00_0000_0010,
        S_ACC  = 10'b00_0000_0100,
        S_RND  = 10'b00_0000_1000,
        S_FILT = 10'b00_0001_0000,
        S_VMUL = 10'b00_0010_0000,
        S_VADD = 10'b00_0100_0000,
        S_PMUL = 10'b00_1000_0000,
        S_PADD = 10'b01_0000_0000,
        S_FIN  = 10'b10_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic [1:0] r_stage, n_stage;
    logic [2:0] r_term, n_term;
    logic [7:0] r_wcnt, n_wcnt;
    logic       r_out_valid, n_out_valid;
    ahdi_pkg::t_op w_op;

    // next state and command
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_stage     = r_stage;
        n_term      = r_term;
        n_wcnt      = r_wcnt;
        n_out_valid = r_out_valid & ~i_out_ready;
        w_op        = ahdi_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (r_wcnt < i_warmup_items) begin
                        n_wcnt = r_wcnt + 8'd1;
                    end else begin
                        w_op    = ahdi_pkg::OP_LOAD;
                        n_axis  = 2'd0;
                        n_stage = 2'd0;
                        n_term  = 3'd0;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                w_op   = ahdi_pkg::OP_MUL;
                n_term = r_term + 3'd1;
                if (r_term == 3'd4) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                w_op    = ahdi_pkg::OP_ACC;
                n_state = S_RND;
            end
            S_RND: begin
                w_op   = ahdi_pkg::OP_RND;
                n_term = 3'd0;
                if (r_stage == 2'(NUM_STAGES - 1)) begin
                    n_stage = 2'd0;
                    n_state = S_FILT;
                end else begin
                    n_stage = r_stage + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_FILT: begin
                w_op    = ahdi_pkg::OP_FILT;
                n_state = S_VMUL;
            end
            S_VMUL: begin
                w_op    = ahdi_pkg::OP_VMUL;
                n_state = S_VADD;
            end
            S_VADD: begin
                w_op    = ahdi_pkg::OP_VADD;
                n_state = S_PMUL;
            end
            S_PMUL: begin
                w_op    = ahdi_pkg::OP_PMUL;
                n_state = S_PADD;
            end
            S_PADD: begin
                w_op = ahdi_pkg::OP_PADD;
                if (r_axis == 2'(NUM_AXES - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    w_op        = ahdi_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 2'd0;
            r_stage     <= 2'd0;
            r_term      <= 3'd0;
            r_wcnt      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_stage     <= n_stage;
            r_term      <= n_term;
            r_wcnt      <= n_wcnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.op    = w_op;
    assign o_cmd.axis  = r_axis;
    assign o_cmd.stage = r_stage;
    assign o_cmd.term  = r_term;

endmodule

`default_nettype wire

// ----- sv/ahdi_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdi_dp
// Datapath: one shared 33x33 multiplier, biquad accumulator, rotating
// history ring, velocity and position integrators, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ahdi_dp #(
    parameter int NUM_STAGES = 2,
    parameter int NUM_AXES   = 3
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  ahdi_pkg::t_dp_cmd            i_cmd,
    input  wire  [ahdi_pkg::IN_W-1:0]    i_in_data,
    input  wire  [31:0]                  i_vel_step,
    input  wire  [31:0]                  i_pos_step,
    output logic [ahdi_pkg::OUT_W-1:0]   o_out_data
);

    localparam int NG = NUM_AXES * NUM_STAGES;

    logic signed [15:0] r_in   [ahdi_pkg::AXES_MAX];
    logic signed [31:0] r_hist [NG][4];
    logic signed [31:0] r_sig;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [15:0] r_filt;
    logic signed [31:0] r_vel  [ahdi_pkg::AXES_MAX];
    logic signed [31:0] r_pos  [ahdi_pkg::AXES_MAX];
    logic signed [15:0] r_res_filt [ahdi_pkg::AXES_MAX];
    logic signed [31:0] r_res_vel  [ahdi_pkg::AXES_MAX];
    logic signed [31:0] r_res_pos  [ahdi_pkg::AXES_MAX];
    logic signed [15:0] r_out_filt [ahdi_pkg::AXES_MAX];
    logic signed [31:0] r_out_vel  [ahdi_pkg::AXES_MAX];
    logic signed [31:0] r_out_pos  [ahdi_pkg::AXES_MAX];

    logic signed [31:0] w_x;
    logic signed [31:0] w_opnd;
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mp;
    logic signed [63:0] w_term;
    logic signed [31:0] w_y;
    logic signed [63:0] w_vsum, w_psum;
    logic signed [31:0] w_vel_new, w_pos_new;

    // stage input: scaled sample on the first stage, previous output after
    assign w_x = (i_cmd.stage == 2'd0) ? 32'(r_in[i_cmd.axis]) <<< 4 : r_sig;

    // operand select for the five biquad terms
    always_comb begin
        case (i_cmd.term)
            3'd0:    w_opnd = w_x;
            3'd1:    w_opnd = r_hist[0][0];
            3'd2:    w_opnd = r_hist[0][1];
            3'd3:    w_opnd = r_hist[0][2];
            3'd4:    w_opnd = r_hist[0][3];
            default: w_opnd = 32'sd0;
        endcase
    end

    // shared multiplier operands
    always_comb begin
        case (i_cmd.op)
            ahdi_pkg::OP_VMUL: begin
                w_ma = 33'(r_filt);
                w_mb = $signed({1'b0, i_vel_step});
            end
            ahdi_pkg::OP_PMUL: begin
                w_ma = 33'(r_vel[i_cmd.axis]);
                w_mb = $signed({1'b0, i_pos_step});
            end
            default: begin
                w_ma = 33'(ahdi_pkg::coef(i_cmd.stage, i_cmd.term));
                w_mb = 33'(w_opnd);
            end
        endcase
    end

    assign w_mp   = w_ma * w_mb;
    assign w_term = r_prod >>> 3;
    assign w_y    = ahdi_pkg::sat32((r_acc + 64'sd67108864) >>> 27);
    assign w_vsum = 64'(r_vel[i_cmd.axis]) + ((r_prod + 64'sd524288) >>> 20);
    assign w_psum = 64'(r_pos[i_cmd.axis]) + ((r_prod + 64'sd8388608) >>> 24);
    assign w_vel_new = ahdi_pkg::sat32(w_vsum);
    assign w_pos_new = ahdi_pkg::sat32(w_psum);

    // product, accumulator, working sample
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ahdi_pkg::OP_LOAD: begin
                r_in[0] <= i_in_data[15:0];
                r_in[1] <= i_in_data[31:16];
                r_in[2] <= i_in_data[47:32];
            end
            ahdi_pkg::OP_MUL: begin
                r_prod <= w_mp[63:0];
                r_acc  <= (i_cmd.term == 3'd0) ? 64'sd0 : r_acc + w_term;
            end
            ahdi_pkg::OP_ACC: begin
                r_acc <= r_acc + w_term;
            end
            ahdi_pkg::OP_RND: begin
                r_sig <= w_y;
            end
            ahdi_pkg::OP_FILT: begin
                r_filt <= ahdi_pkg::sat16((64'(r_sig) + 64'sd8) >>> 4);
            end
            ahdi_pkg::OP_VMUL, ahdi_pkg::OP_PMUL: begin
                r_prod <= w_mp[63:0];
            end
            ahdi_pkg::OP_VADD: begin
                r_res_filt[i_cmd.axis] <= r_filt;
            end
            ahdi_pkg::OP_PADD: begin
                r_res_vel[i_cmd.axis] <= r_vel[i_cmd.axis];
                r_res_pos[i_cmd.axis] <= w_pos_new;
            end
            default: begin
            end
        endcase
    end

    // history ring: head group is the current axis and stage, rotate on round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NG; g++) begin
                for (int k = 0; k < 4; k++) begin
                    r_hist[g][k] <= 32'sd0;
                end
            end
        end else if (i_cmd.op == ahdi_pkg::OP_RND) begin
            for (int g = 0; g < NG - 1; g++) begin
                r_hist[g] <= r_hist[g+1];
            end
            r_hist[NG-1][0] <= w_x;
            r_hist[NG-1][1] <= r_hist[0][0];
            r_hist[NG-1][2] <= w_y;
            r_hist[NG-1][3] <= r_hist[0][2];
        end
    end

    // integrators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < ahdi_pkg::AXES_MAX; a++) begin
                r_vel[a]      <= 32'sd0;
                r_pos[a]      <= 32'sd0;
                r_out_filt[a] <= 16'sd0;
                r_out_vel[a]  <= 32'sd0;
                r_out_pos[a]  <= 32'sd0;
            end
        end else begin
            case (i_cmd.op)
                ahdi_pkg::OP_VADD: begin
                    r_vel[i_cmd.axis] <= w_vel_new;
                end
                ahdi_pkg::OP_PADD: begin
                    r_pos[i_cmd.axis] <= w_pos_new;
                end
                ahdi_pkg::OP_OUT: begin
                    for (int a = 0; a < NUM_AXES; a++) begin
                        r_out_filt[a] <= r_res_filt[a];
                        r_out_vel[a]  <= r_res_vel[a];
                        r_out_pos[a]  <= r_res_pos[a];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_data = {r_out_pos[2], r_out_pos[1], r_out_pos[0],
                         r_out_vel[2], r_out_vel[1], r_out_vel[0],
                         r_out_filt[2], r_out_filt[1], r_out_filt[0]};

endmodule

`default_nettype wire

// ----- sv/accel_highpass_double_integrator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_highpass_double_integrator
// Three-axis acceleration high-pass biquad cascade with velocity and
// position integration.
// ----------------------------------------------------------------------------
// Each item is accepted in the idle state, then runs through the multiply,
// accumulate and round steps of every stage and the filter and integration
// steps of every axis before its result is loaded into the output register.
// All products share one 33x33 multiplier; the next request is taken only
// once the sequencer is idle again. A result still waiting in the output
// register holds the sequencer, and so the input, until it is taken. The
// first warmup_items requests after reset are absorbed and give no result.
`default_nettype none

module accel_highpass_double_integrator #(
    parameter int NUM_STAGES = 2,
    parameter int NUM_AXES   = 3
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // acc_x, acc_y, acc_z
    input  wire  [ahdi_pkg::IN_W-1:0]         i_s_axis_tdata,
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // filt_x, filt_y, filt_z, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z
    output logic [ahdi_pkg::OUT_W-1:0]        o_m_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    input  wire                               i_cfg_wr_en,
    input  wire  [ahdi_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire  [ahdi_pkg::CFG_W-1:0]        i_cfg_wr_data
);

    logic [31:0] r_vel_step;
    logic [31:0] r_pos_step;
    logic [7:0]  r_warmup;
    ahdi_pkg::t_dp_cmd w_cmd;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_step <= ahdi_pkg::VEL_STEP_RST;
            r_pos_step <= ahdi_pkg::POS_STEP_RST;
            r_warmup   <= ahdi_pkg::WARMUP_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                ahdi_pkg::REG_VEL_STEP: r_vel_step <= i_cfg_wr_data;
                ahdi_pkg::REG_POS_STEP: r_pos_step <= i_cfg_wr_data;
                ahdi_pkg::REG_WARMUP:   r_warmup   <= i_cfg_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    ahdi_ctrl #(
        .NUM_STAGES (NUM_STAGES),
        .NUM_AXES   (NUM_AXES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_axis_tvalid),
        .o_in_ready     (o_s_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .i_warmup_items (r_warmup),
        .o_cmd          (w_cmd)
    );

    ahdi_dp #(
        .NUM_STAGES (NUM_STAGES),
        .NUM_AXES   (NUM_AXES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_s_axis_tdata),
        .i_vel_step (r_vel_step),
        .i_pos_step (r_pos_step),
        .o_out_data (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- sv/ahdi_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdi_chk
// Port-level checks for the high-pass and integration block.
// ----------------------------------------------------------------------------
`default_nettype none

module ahdi_chk (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             o_s_axis_tready,
    input wire [ahdi_pkg::OUT_W-1:0]       o_m_axis_tdata,
    input wire                             o_m_axis_tvalid,
    input wire                             i_m_axis_tready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // reset leaves no result pending
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // reset returns to accepting requests
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("not ready after reset");

    // a new result is only loaded while the sequencer is busy
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind accel_highpass_double_integrator ahdi_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

`default_nettype wire
